/* rtl/core/krt_pkg.sv */
`timescale 1ns / 1ps

package krt_pkg;

    localparam int DEPTH = 64;
    localparam int IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    localparam int ACT_W   = 3;
    localparam int KEY_W   = 16;
    localparam int AGE_W   = 8;
    localparam int MARKS_W = 17;
    localparam int STAT_W  = 3;

    localparam logic [MARKS_W-1:0] MARK_MAX = MARKS_W'(100000);

    localparam logic [ACT_W-1:0] ACT_INSERT = 3'd0;
    localparam logic [ACT_W-1:0] ACT_LOOKUP = 3'd1;
    localparam logic [ACT_W-1:0] ACT_UPDATE = 3'd2;
    localparam logic [ACT_W-1:0] ACT_DELETE = 3'd3;
    localparam logic [ACT_W-1:0] ACT_LIST   = 3'd4;

    localparam logic [STAT_W-1:0] STAT_OK       = 3'd0;
    localparam logic [STAT_W-1:0] STAT_NOTFOUND = 3'd1;
    localparam logic [STAT_W-1:0] STAT_DUP      = 3'd2;
    localparam logic [STAT_W-1:0] STAT_FULL     = 3'd3;
    localparam logic [STAT_W-1:0] STAT_EMPTY    = 3'd4;

    typedef struct packed {
        logic [KEY_W-1:0]   key;
        logic [AGE_W-1:0]   age;
        logic [MARKS_W-1:0] marks;
    } rec_t;

    typedef struct packed {
        logic             ring_en;
        logic             compact_en;
        logic [IDX_W-1:0] del_idx;
    } ring_ctl_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_SHIFT,
        ST_RESP
    } state_t;

endpackage

/* rtl/core/krt_cell.sv */
`timescale 1ns / 1ps

module krt_cell (
    input  logic                    aclk,
    input  logic [krt_pkg::IDX_W-1:0] cell_idx,
    input  krt_pkg::ring_ctl_t      ctl,
    input  krt_pkg::rec_t           nbr_rec,
    output krt_pkg::rec_t           rec
);
    import krt_pkg::*;

    rec_t rec_reg;
    logic load;

    assign load = ctl.ring_en || (ctl.compact_en && (cell_idx >= ctl.del_idx));

    always_ff @(posedge aclk) begin
        if (load) begin
            rec_reg <= nbr_rec;
        end
    end

    assign rec = rec_reg;

endmodule

/* rtl/core/krt_ctrl.sv */
`timescale 1ns / 1ps

module krt_ctrl (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        s_valid,
    output logic                        s_ready,
    input  logic [krt_pkg::ACT_W-1:0]   s_action,
    input  logic [krt_pkg::KEY_W-1:0]   s_key,
    input  logic [krt_pkg::AGE_W-1:0]   s_age_in,
    input  logic [krt_pkg::MARKS_W-1:0] s_marks_in,
    output logic                        m_valid,
    input  logic                        m_ready,
    output logic [krt_pkg::STAT_W-1:0]  m_status,
    output logic [krt_pkg::KEY_W-1:0]   m_key_out,
    output logic [krt_pkg::AGE_W-1:0]   m_age_out,
    output logic [krt_pkg::MARKS_W-1:0] m_marks_out,
    output logic [krt_pkg::CNT_W-1:0]   m_entries,
    output logic                        m_last,
    input  krt_pkg::rec_t               head_rec,
    output krt_pkg::rec_t               tail_rec,
    output krt_pkg::ring_ctl_t          ring_ctl
);
    import krt_pkg::*;

    state_t              state_reg, state_next;
    logic [ACT_W-1:0]    act_reg;
    rec_t                req_reg;
    rec_t                cap_reg;
    logic [IDX_W-1:0]    p_reg;
    logic [IDX_W-1:0]    idx_reg;
    logic                hit_reg;
    logic                full_reg;
    logic [CNT_W-1:0]    fill_reg, fill_next;

    logic                m_valid_reg;
    logic [STAT_W-1:0]   out_status_reg;
    rec_t                out_rec_reg;
    logic [CNT_W-1:0]    out_entries_reg;
    logic                out_last_reg;

    logic                accept;
    logic                slot_free;
    logic                in_fill;
    logic                match;
    logic                is_list;
    logic                step_en;
    logic                scan_end;
    logic                insert_here;
    logic                write_new;
    logic                load_list;
    logic                load_resp;
    logic [STAT_W-1:0]   resp_status;
    rec_t                resp_rec;
    rec_t                req_in;
    logic [MARKS_W-1:0]  marks_sat;

    assign marks_sat   = (s_marks_in > MARK_MAX) ? MARK_MAX : s_marks_in;
    assign req_in      = '{key: s_key, age: s_age_in, marks: marks_sat};
    assign accept      = s_valid && s_ready;
    assign slot_free   = !m_valid_reg || m_ready;
    assign in_fill     = CNT_W'(p_reg) < fill_reg;
    assign match       = in_fill && (head_rec.key == req_reg.key);
    assign is_list     = (act_reg == ACT_LIST);
    assign scan_end    = step_en && (p_reg == IDX_W'(DEPTH - 1));
    assign insert_here = (act_reg == ACT_INSERT) && (CNT_W'(p_reg) == fill_reg) && !hit_reg;
    assign write_new   = ((act_reg == ACT_UPDATE) && match) || insert_here;
    assign tail_rec    = write_new ? req_reg : head_rec;

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    if ((s_action == ACT_INSERT) && (fill_reg == CNT_W'(DEPTH))) begin
                        state_next = ST_RESP;
                    end else if ((s_action == ACT_LIST) && (fill_reg == '0)) begin
                        state_next = ST_RESP;
                    end else if (s_action inside {ACT_INSERT, ACT_LOOKUP, ACT_UPDATE,
                                                  ACT_DELETE, ACT_LIST}) begin
                        state_next = ST_SCAN;
                    end
                end
            end
            ST_SCAN: begin
                if (scan_end) begin
                    if (is_list) begin
                        state_next = ST_IDLE;
                    end else if ((act_reg == ACT_DELETE) && (hit_reg || match)) begin
                        state_next = ST_SHIFT;
                    end else begin
                        state_next = ST_RESP;
                    end
                end
            end
            ST_SHIFT: begin
                state_next = ST_RESP;
            end
            ST_RESP: begin
                if (slot_free) begin
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb begin
        s_ready             = (state_reg == ST_IDLE);
        step_en             = (state_reg == ST_SCAN) && (!(is_list && in_fill) || slot_free);
        load_list           = step_en && is_list && in_fill;
        load_resp           = (state_reg == ST_RESP) && slot_free;
        ring_ctl.ring_en    = step_en;
        ring_ctl.compact_en = (state_reg == ST_SHIFT);
        ring_ctl.del_idx    = idx_reg;
    end

    always_comb begin
        resp_status = STAT_NOTFOUND;
        resp_rec    = '{key: req_reg.key, age: '0, marks: '0};
        case (act_reg)
            ACT_INSERT: begin
                if (full_reg) begin
                    resp_status = STAT_FULL;
                end else if (hit_reg) begin
                    resp_status = STAT_DUP;
                end else begin
                    resp_status = STAT_OK;
                    resp_rec    = req_reg;
                end
            end
            ACT_LOOKUP, ACT_DELETE: begin
                if (hit_reg) begin
                    resp_status = STAT_OK;
                    resp_rec    = cap_reg;
                end
            end
            ACT_UPDATE: begin
                if (hit_reg) begin
                    resp_status = STAT_OK;
                    resp_rec    = req_reg;
                end
            end
            ACT_LIST: begin
                resp_status = STAT_EMPTY;
                resp_rec    = '0;
            end
            default: begin
                resp_status = STAT_NOTFOUND;
            end
        endcase
    end

    always_comb begin
        fill_next = fill_reg;
        if (scan_end && (act_reg == ACT_INSERT) && !(hit_reg || match)) begin
            fill_next = fill_reg + CNT_W'(1);
        end else if (state_reg == ST_SHIFT) begin
            fill_next = fill_reg - CNT_W'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            fill_reg    <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            fill_reg  <= fill_next;
            if (load_list || load_resp) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            act_reg  <= s_action;
            req_reg  <= req_in;
            p_reg    <= '0;
            hit_reg  <= 1'b0;
            full_reg <= (fill_reg == CNT_W'(DEPTH));
        end else if (step_en) begin
            p_reg <= p_reg + IDX_W'(1);
            if (match && !hit_reg) begin
                hit_reg <= 1'b1;
                cap_reg <= head_rec;
                idx_reg <= p_reg;
            end
        end
        if (load_list) begin
            out_status_reg  <= STAT_OK;
            out_rec_reg     <= head_rec;
            out_entries_reg <= fill_reg;
            out_last_reg    <= (CNT_W'(p_reg) + CNT_W'(1)) == fill_reg;
        end else if (load_resp) begin
            out_status_reg  <= resp_status;
            out_rec_reg     <= resp_rec;
            out_entries_reg <= fill_reg;
            out_last_reg    <= 1'b1;
        end
    end

    assign m_valid     = m_valid_reg;
    assign m_status    = out_status_reg;
    assign m_key_out   = out_rec_reg.key;
    assign m_age_out   = out_rec_reg.age;
    assign m_marks_out = out_rec_reg.marks;
    assign m_entries   = out_entries_reg;
    assign m_last      = out_last_reg;

endmodule

/* rtl/core/keyed_record_table.sv */
`timescale 1ns / 1ps
// Keyed record table holding up to DEPTH records in insertion order.
// Requests enter on the s_ channel (valid/ready) with an action, a key, an
// age and a mark; results leave on the m_ channel (valid/ready), and m_last
// flags the final result of a request. Actions 5 to 7 are dropped silently.
// The records sit in a ring of cells that rotates one place per cycle while
// a request is worked on; the controller compares and edits the record at
// the head, so each request that scans walks the whole ring once.
// Insert, lookup and update scan the ring and then load the result; a delete
// that finds its key first closes the gap. Insert into a full table and
// list of an empty table skip the scan and load their result directly. List
// emits one item per held record as the ring passes, then rotates the rest.
// One request is in flight at a time; a new request is taken only when the
// controller is idle again. A stalled receiver holds the output register;
// during a list the ring stops until the item is taken.
// Synchronous active-low reset empties the table (record count zero) and
// drops any pending result; the record storage itself is not cleared.
module keyed_record_table (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        s_valid,
    output logic                        s_ready,
    input  logic [krt_pkg::ACT_W-1:0]   s_action,
    input  logic [krt_pkg::KEY_W-1:0]   s_key,
    input  logic [krt_pkg::AGE_W-1:0]   s_age_in,
    input  logic [krt_pkg::MARKS_W-1:0] s_marks_in,
    output logic                        m_valid,
    input  logic                        m_ready,
    output logic [krt_pkg::STAT_W-1:0]  m_status,
    output logic [krt_pkg::KEY_W-1:0]   m_key_out,
    output logic [krt_pkg::AGE_W-1:0]   m_age_out,
    output logic [krt_pkg::MARKS_W-1:0] m_marks_out,
    output logic [krt_pkg::CNT_W-1:0]   m_entries,
    output logic                        m_last
);
    import krt_pkg::*;

    rec_t      cell_rec [DEPTH];
    rec_t      tail_rec;
    ring_ctl_t ring_ctl;

    krt_ctrl u_ctrl (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_valid     (s_valid),
        .s_ready     (s_ready),
        .s_action    (s_action),
        .s_key       (s_key),
        .s_age_in    (s_age_in),
        .s_marks_in  (s_marks_in),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .m_status    (m_status),
        .m_key_out   (m_key_out),
        .m_age_out   (m_age_out),
        .m_marks_out (m_marks_out),
        .m_entries   (m_entries),
        .m_last      (m_last),
        .head_rec    (cell_rec[0]),
        .tail_rec    (tail_rec),
        .ring_ctl    (ring_ctl)
    );

    for (genvar i = 0; i < DEPTH; i++) begin : g_cell
        rec_t nbr;
        if (i == DEPTH - 1) begin : g_tail
            assign nbr = tail_rec;
        end else begin : g_body
            assign nbr = cell_rec[i + 1];
        end
        krt_cell u_cell (
            .aclk     (aclk),
            .cell_idx (IDX_W'(i)),
            .ctl      (ring_ctl),
            .nbr_rec  (nbr),
            .rec      (cell_rec[i])
        );
    end

endmodule

/* test/keyed_record_table_tb.sv */
`timescale 1ns / 1ps

module keyed_record_table_tb;
    import krt_pkg::*;

    localparam int ACT_LAST_CODE = (1 << ACT_W) - 1;
    localparam int MAX_SHOWN     = 10;

    typedef struct packed {
        logic [STAT_W-1:0]  status;
        logic [KEY_W-1:0]   key;
        logic [AGE_W-1:0]   age;
        logic [MARKS_W-1:0] marks;
        logic [CNT_W-1:0]   entries;
        logic               last;
    } table_result_t;

    logic               aclk;
    logic               aresetn;
    logic               s_valid;
    logic               s_ready;
    logic [ACT_W-1:0]   s_action;
    logic [KEY_W-1:0]   s_key;
    logic [AGE_W-1:0]   s_age_in;
    logic [MARKS_W-1:0] s_marks_in;
    logic               m_valid;
    logic               m_ready;
    logic [STAT_W-1:0]  m_status;
    logic [KEY_W-1:0]   m_key_out;
    logic [AGE_W-1:0]   m_age_out;
    logic [MARKS_W-1:0] m_marks_out;
    logic [CNT_W-1:0]   m_entries;
    logic               m_last;

    logic [KEY_W-1:0]   held_key   [DEPTH];
    logic [AGE_W-1:0]   held_age   [DEPTH];
    logic [MARKS_W-1:0] held_marks [DEPTH];
    int                 held_count;
    table_result_t      expected_results[$];
    int                 mismatch_count;
    int                 send_idle_pct;
    int                 recv_idle_pct;

    keyed_record_table dut (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_valid    (s_valid),
        .s_ready    (s_ready),
        .s_action   (s_action),
        .s_key      (s_key),
        .s_age_in   (s_age_in),
        .s_marks_in (s_marks_in),
        .m_valid    (m_valid),
        .m_ready    (m_ready),
        .m_status   (m_status),
        .m_key_out  (m_key_out),
        .m_age_out  (m_age_out),
        .m_marks_out(m_marks_out),
        .m_entries  (m_entries),
        .m_last     (m_last)
    );

    always #5 aclk = ~aclk;

    always @(negedge aclk) begin
        m_ready <= ($urandom_range(0, 99) >= recv_idle_pct);
    end

    function automatic int find_record(logic [KEY_W-1:0] key);
        for (int i = 0; i < held_count; i++) begin
            if (held_key[i] == key) begin
                return i;
            end
        end
        return -1;
    endfunction

    function automatic void expect_result(logic [STAT_W-1:0] status, logic [KEY_W-1:0] key,
                                          logic [AGE_W-1:0] age, logic [MARKS_W-1:0] marks,
                                          logic last);
        table_result_t r;
        r.status  = status;
        r.key     = key;
        r.age     = age;
        r.marks   = marks;
        r.entries = CNT_W'(held_count);
        r.last    = last;
        expected_results.push_back(r);
    endfunction

    function automatic void predict_request(logic [ACT_W-1:0] action, logic [KEY_W-1:0] key,
                                            logic [AGE_W-1:0] age, logic [MARKS_W-1:0] marks);
        int                 idx;
        logic [MARKS_W-1:0] mark_sat;
        logic [KEY_W-1:0]   gone_key;
        logic [AGE_W-1:0]   gone_age;
        logic [MARKS_W-1:0] gone_marks;
        mark_sat = (marks > MARK_MAX) ? MARK_MAX : marks;
        idx = find_record(key);
        case (action)
            ACT_INSERT: begin
                if (held_count >= DEPTH) begin
                    expect_result(STAT_FULL, key, '0, '0, 1'b1);
                end else if (idx >= 0) begin
                    expect_result(STAT_DUP, key, '0, '0, 1'b1);
                end else begin
                    held_key[held_count]   = key;
                    held_age[held_count]   = age;
                    held_marks[held_count] = mark_sat;
                    held_count++;
                    expect_result(STAT_OK, key, age, mark_sat, 1'b1);
                end
            end
            ACT_LOOKUP, ACT_UPDATE, ACT_DELETE: begin
                if (idx < 0) begin
                    expect_result(STAT_NOTFOUND, key, '0, '0, 1'b1);
                end else if (action == ACT_LOOKUP) begin
                    expect_result(STAT_OK, held_key[idx], held_age[idx], held_marks[idx], 1'b1);
                end else if (action == ACT_UPDATE) begin
                    held_age[idx]   = age;
                    held_marks[idx] = mark_sat;
                    expect_result(STAT_OK, key, age, mark_sat, 1'b1);
                end else begin
                    gone_key   = held_key[idx];
                    gone_age   = held_age[idx];
                    gone_marks = held_marks[idx];
                    for (int i = idx; i + 1 < held_count; i++) begin
                        held_key[i]   = held_key[i + 1];
                        held_age[i]   = held_age[i + 1];
                        held_marks[i] = held_marks[i + 1];
                    end
                    held_count--;
                    expect_result(STAT_OK, gone_key, gone_age, gone_marks, 1'b1);
                end
            end
            ACT_LIST: begin
                if (held_count == 0) begin
                    expect_result(STAT_EMPTY, '0, '0, '0, 1'b1);
                end else begin
                    for (int i = 0; i < held_count; i++) begin
                        expect_result(STAT_OK, held_key[i], held_age[i], held_marks[i],
                                      i == held_count - 1);
                    end
                end
            end
            default: ;
        endcase
    endfunction

    function automatic string show_result(table_result_t r);
        return $sformatf("status=%0d key=%h age=%h marks=%0d entries=%0d last=%0b",
                         r.status, r.key, r.age, r.marks, r.entries, r.last);
    endfunction

    always @(posedge aclk) begin
        table_result_t got;
        table_result_t want;
        if (aresetn && m_valid && m_ready) begin
            got.status  = m_status;
            got.key     = m_key_out;
            got.age     = m_age_out;
            got.marks   = m_marks_out;
            got.entries = m_entries;
            got.last    = m_last;
            if (expected_results.size() == 0) begin
                mismatch_count++;
                if (mismatch_count <= MAX_SHOWN) begin
                    $display("%0t: unexpected result: %s", $time, show_result(got));
                end
            end else begin
                want = expected_results.pop_front();
                if (got !== want) begin
                    mismatch_count++;
                    if (mismatch_count <= MAX_SHOWN) begin
                        $display("%0t: mismatch\n  expected %s\n  actual   %s", $time,
                                 show_result(want), show_result(got));
                    end
                end
            end
        end
    end

    // Called and returning at a falling edge; the item is predicted at the
    // rising edge where it is accepted.
    task automatic send_request(logic [ACT_W-1:0] action, logic [KEY_W-1:0] key,
                                logic [AGE_W-1:0] age, logic [MARKS_W-1:0] marks);
        while ($urandom_range(0, 99) < send_idle_pct) begin
            s_valid <= 1'b0;
            @(negedge aclk);
        end
        s_valid    <= 1'b1;
        s_action   <= action;
        s_key      <= key;
        s_age_in   <= age;
        s_marks_in <= marks;
        do @(posedge aclk); while (!s_ready);
        predict_request(action, key, age, marks);
        @(negedge aclk);
    endtask

    task automatic wait_until_drained();
        s_valid <= 1'b0;
        while (expected_results.size() != 0) begin
            @(negedge aclk);
        end
        repeat (DEPTH + 4) @(negedge aclk);
    endtask

    task automatic test_edge_cases();
        send_request(ACT_LIST, '0, '0, '0);
        send_request(ACT_LOOKUP, 16'h1234, '0, '0);
        send_request(ACT_UPDATE, 16'h0001, 8'h11, MARKS_W'(500));
        send_request(ACT_DELETE, 16'hFFFF, '0, '0);
        send_request(ACT_INSERT, 16'h0000, 8'h00, '0);
        send_request(ACT_INSERT, 16'hFFFF, 8'hFF, MARK_MAX);
        send_request(ACT_INSERT, 16'h5A5A, 8'h80, '1);
        send_request(ACT_INSERT, 16'h0000, 8'h33, MARKS_W'(777));
        send_request(ACT_LOOKUP, 16'hFFFF, '0, '0);
        send_request(ACT_LOOKUP, 16'h5A5A, '1, '1);
        send_request(ACT_UPDATE, 16'h0000, 8'h7F, MARKS_W'(MARK_MAX + 1));
        send_request(ACT_LIST, '0, '0, '0);
        for (int a = ACT_LIST + 1; a <= ACT_LAST_CODE; a++) begin
            send_request(ACT_W'(a), 16'h0000, 8'hFF, '1);
        end
        send_request(ACT_DELETE, 16'hFFFF, '0, '0);
        send_request(ACT_LIST, '0, '0, '0);
        send_request(ACT_LOOKUP, 16'hFFFF, '0, '0);
        send_request(ACT_DELETE, 16'h0000, '0, '0);
        send_request(ACT_DELETE, 16'h5A5A, '0, '0);
        send_request(ACT_LIST, '0, '0, '0);
        send_request(ACT_DELETE, 16'h5A5A, '0, '0);
        wait_until_drained();
    endtask

    task automatic test_full_table();
        for (int i = 0; i < DEPTH; i++) begin
            send_request(ACT_INSERT, KEY_W'(i * 997 + 3), AGE_W'($urandom),
                         MARKS_W'($urandom_range(0, MARK_MAX)));
        end
        send_request(ACT_INSERT, 16'hBEEF, 8'h01, MARKS_W'(1));
        // A held key must still be refused as full, not as a duplicate.
        send_request(ACT_INSERT, held_key[DEPTH / 2], 8'h02, MARKS_W'(2));
        send_request(ACT_LIST, '0, '0, '0);
        send_request(ACT_LOOKUP, held_key[DEPTH - 1], '0, '0);
        send_request(ACT_UPDATE, held_key[0], 8'h55, MARKS_W'(12345));
        send_request(ACT_DELETE, held_key[0], '0, '0);
        send_request(ACT_DELETE, held_key[held_count - 1], '0, '0);
        send_request(ACT_DELETE, held_key[held_count / 2], '0, '0);
        send_request(ACT_LIST, '0, '0, '0);
        send_request(ACT_INSERT, 16'hBEEF, 8'hAA, MARK_MAX);
        wait_until_drained();
    endtask

    task automatic test_mixed_traffic(int n_items);
        int                 sent;
        int                 pick;
        logic [ACT_W-1:0]   action;
        logic [KEY_W-1:0]   key;
        logic [MARKS_W-1:0] marks;
        sent = 0;
        while (sent < n_items) begin
            pick = $urandom_range(0, 99);
            if (pick < 4) begin
                action = ACT_W'($urandom_range(ACT_LIST + 1, ACT_LAST_CODE));
            end else if (pick < 40) begin
                action = ACT_INSERT;
            end else if (pick < 55) begin
                action = ACT_LOOKUP;
            end else if (pick < 70) begin
                action = ACT_UPDATE;
            end else if (pick < 93) begin
                action = ACT_DELETE;
            end else begin
                action = ACT_LIST;
            end
            pick = $urandom_range(0, 9);
            if (pick < 6 && held_count > 0) begin
                key = held_key[$urandom_range(0, held_count - 1)];
            end else if (pick < 8) begin
                key = KEY_W'($urandom_range(0, 31));
            end else begin
                key = KEY_W'($urandom);
            end
            if ($urandom_range(0, 9) == 0) begin
                marks = MARKS_W'($urandom);
            end else begin
                marks = MARKS_W'($urandom_range(0, MARK_MAX));
            end
            send_request(action, key, AGE_W'($urandom), marks);
            if (action <= ACT_LIST) begin
                sent++;
            end
        end
        wait_until_drained();
    endtask

    initial begin
        aclk           = 1'b0;
        aresetn        = 1'b0;
        s_valid        = 1'b0;
        s_action       = ACT_INSERT;
        s_key          = '0;
        s_age_in       = '0;
        s_marks_in     = '0;
        m_ready        = 1'b0;
        held_count     = 0;
        mismatch_count = 0;
        send_idle_pct  = 21;
        recv_idle_pct  = 71;
        repeat (5) @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        test_edge_cases();
        test_full_table();
        test_mixed_traffic(130);
        send_idle_pct = 71;
        recv_idle_pct = 21;
        test_mixed_traffic(130);
        send_idle_pct = 0;
        recv_idle_pct = 0;
        test_mixed_traffic(130);

        if (mismatch_count == 0) begin
            $display("PASS keyed_record_table");
        end else begin
            $display("FAIL keyed_record_table");
        end
        $finish;
    end

    initial begin
        #(50_000_000);
        $display("FAIL keyed_record_table");
        $finish;
    end

endmodule
